/* rtl/core/dgcpsd_pkg.sv */
// types and constants shared by the dual gate charge psd block
// no dependencies
`default_nettype none

package dgcpsd_pkg;

    localparam int ACC_W        = 23;
    localparam int PSD_W        = 16;
    localparam int GATE_START_W = 10;
    localparam int GATE_END_W   = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int REM_W        = 39;
    localparam int DIV_STEPS    = 16;
    localparam int CNT_W        = 4;
    localparam int NUM_SHIFT    = 15;
    localparam int DEN_SHIFT    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_END   = 2'd3;

    localparam logic [GATE_START_W-1:0] RST_LONG_START  = 10'd4;
    localparam logic [GATE_END_W-1:0]   RST_LONG_END    = 11'd54;
    localparam logic [GATE_START_W-1:0] RST_SHORT_START = 10'd4;
    localparam logic [GATE_END_W-1:0]   RST_SHORT_END   = 11'd14;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 23'sd4194303;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -23'sd4194303;
    localparam logic signed [PSD_W-1:0] PSD_MAX = 16'sh7FFF;
    localparam logic signed [PSD_W-1:0] PSD_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        S_ACC,
        S_ABS,
        S_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic acc_en;
        logic abs_en;
        logic init_en;
        logic div_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > (ACC_W+1)'(ACC_MAX)) begin
            r = ACC_MAX;
        end else if (v < (ACC_W+1)'(ACC_MIN)) begin
            r = ACC_MIN;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dual_gate_charge_psd.sv */
// dual gate charge integration with pulse shape discrimination, top level
// depends on dgcpsd_pkg, dgcpsd_ctrl, dgcpsd_datapath
//
// input channel: one adc word per accepted word (i_in_valid high, o_in_stall low),
// carrying the sample, the pulse baseline and a last flag. baseline minus sample
// is summed into a long and a short gate sum by sample position.
// output channel: one word per pulse, after its last word, with both charges,
// psd = (long - short) / long in signed q1.14 and a psd valid flag.
// throughput: one word per cycle within a pulse. after the last word the input
// stalls through the prepare steps (abs, init), 16 divider steps and the load step
// while the restoring divider forms the ratio, one quotient bit per cycle.
// the output register holds a finished word while i_out_stall is high; the
// next pulse is taken meanwhile, and its result waits in the divider until
// the held word is taken.
// reset: gates return to 4..54 (long) and 4..14 (short), sums and position clear,
// output empty. gate registers are to be written by the user only while the block
// is idle; the block itself does not enforce it.
`default_nettype none

module dual_gate_charge_psd #(
    parameter int MAX_PULSE_SAMPLES = 1024,
    parameter int SAMPLE_BITS       = 12
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [dgcpsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [dgcpsd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [SAMPLE_BITS-1:0]               i_adc_sample,
    input  wire [SAMPLE_BITS-1:0]               i_pulse_baseline,
    input  wire                                 i_last_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [dgcpsd_pkg::ACC_W-1:0] o_long_charge,
    output logic signed [dgcpsd_pkg::ACC_W-1:0] o_short_charge,
    output logic signed [dgcpsd_pkg::PSD_W-1:0] o_psd_ratio,
    output logic                                o_psd_valid
);

    dgcpsd_pkg::t_cmd    cmd;
    dgcpsd_pkg::t_status status;

    dgcpsd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_in_stall    (o_in_stall)
    );

    dgcpsd_datapath #(
        .MAX_PULSE_SAMPLES (MAX_PULSE_SAMPLES),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_adc_sample     (i_adc_sample),
        .i_pulse_baseline (i_pulse_baseline),
        .i_last_sample    (i_last_sample),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_long_charge    (o_long_charge),
        .o_short_charge   (o_short_charge),
        .o_psd_ratio      (o_psd_ratio),
        .o_psd_valid      (o_psd_valid)
    );

endmodule

`default_nettype wire

/* rtl/core/dgcpsd_ctrl.sv */
// sequencer: accumulate, prepare, divide, hand off result
// depends on dgcpsd_pkg
`default_nettype none

module dgcpsd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_last_sample,
    input  dgcpsd_pkg::t_status i_status,
    output dgcpsd_pkg::t_cmd    o_cmd,
    output logic                o_in_stall
);

    dgcpsd_pkg::t_state r_state;
    dgcpsd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgcpsd_pkg::S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            dgcpsd_pkg::S_ACC: begin
                o_in_stall   = 1'b0;
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_last_sample) begin
                    n_state = dgcpsd_pkg::S_ABS;
                end
            end
            dgcpsd_pkg::S_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = dgcpsd_pkg::S_INIT;
            end
            dgcpsd_pkg::S_INIT: begin
                o_cmd.init_en = 1'b1;
                n_state       = dgcpsd_pkg::S_DIV;
            end
            dgcpsd_pkg::S_DIV: begin
                o_cmd.div_en = 1'b1;
                if (i_status.div_last) begin
                    n_state = dgcpsd_pkg::S_DONE;
                end
            end
            dgcpsd_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dgcpsd_pkg::S_ACC;
                end
            end
            default: begin
                n_state = dgcpsd_pkg::S_ACC;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_en || o_cmd.out_load || o_cmd.abs_en) |-> o_in_stall)
        else $error("input open while result in progress");

    a_last_to_abs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.acc_en && i_last_sample) |=> o_cmd.abs_en)
        else $error("last word did not start result");

endmodule

`default_nettype wire

/* rtl/core/dgcpsd_datapath.sv */
// gate config, position counter, gate sums, restoring divider, output register
// depends on dgcpsd_pkg
`default_nettype none

module dgcpsd_datapath #(
    parameter int MAX_PULSE_SAMPLES = 1024,
    parameter int SAMPLE_BITS       = 12
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [dgcpsd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [dgcpsd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire [SAMPLE_BITS-1:0]                  i_adc_sample,
    input  wire [SAMPLE_BITS-1:0]                  i_pulse_baseline,
    input  wire                                    i_last_sample,
    input  dgcpsd_pkg::t_cmd                       i_cmd,
    output dgcpsd_pkg::t_status                    o_status,
    input  wire                                    i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [dgcpsd_pkg::ACC_W-1:0]    o_long_charge,
    output logic signed [dgcpsd_pkg::ACC_W-1:0]    o_short_charge,
    output logic signed [dgcpsd_pkg::PSD_W-1:0]    o_psd_ratio,
    output logic                                   o_psd_valid
);

    localparam int ACC_W = dgcpsd_pkg::ACC_W;
    localparam int POS_W = $clog2(MAX_PULSE_SAMPLES + 1);
    localparam int CMP_W = (POS_W > dgcpsd_pkg::GATE_END_W) ? POS_W : dgcpsd_pkg::GATE_END_W;
    localparam int REM_W = dgcpsd_pkg::REM_W;

    logic [dgcpsd_pkg::GATE_START_W-1:0] r_lg_start;
    logic [dgcpsd_pkg::GATE_END_W-1:0]   r_lg_end;
    logic [dgcpsd_pkg::GATE_START_W-1:0] r_sg_start;
    logic [dgcpsd_pkg::GATE_END_W-1:0]   r_sg_end;

    logic [POS_W-1:0]        r_pos;
    logic signed [ACC_W-1:0] r_long;
    logic signed [ACC_W-1:0] r_short;
    logic signed [ACC_W-1:0] r_lc;
    logic signed [ACC_W-1:0] r_sc;
    logic [ACC_W:0]          r_adiff;
    logic [ACC_W-1:0]        r_ad;
    logic                    r_neg;
    logic                    r_zero;
    logic [REM_W-1:0]        r_rem;
    logic [REM_W-1:0]        r_div;
    logic [dgcpsd_pkg::PSD_W-1:0] r_quo;
    logic [dgcpsd_pkg::CNT_W-1:0] r_cnt;
    logic                    r_out_valid;

    logic                    run;
    logic [CMP_W-1:0]        pos_c;
    logic                    in_long;
    logic                    in_short;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [ACC_W-1:0] n_long;
    logic signed [ACC_W-1:0] n_short;
    logic signed [ACC_W:0]   lc_sc;
    logic                    ge;
    logic signed [dgcpsd_pkg::PSD_W-1:0] q_mag;
    logic signed [dgcpsd_pkg::PSD_W-1:0] psd;

    // gate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_start <= dgcpsd_pkg::RST_LONG_START;
            r_lg_end   <= dgcpsd_pkg::RST_LONG_END;
            r_sg_start <= dgcpsd_pkg::RST_SHORT_START;
            r_sg_end   <= dgcpsd_pkg::RST_SHORT_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dgcpsd_pkg::CFG_LONG_START:  r_lg_start <= i_cfg_data[dgcpsd_pkg::GATE_START_W-1:0];
                dgcpsd_pkg::CFG_LONG_END:    r_lg_end   <= i_cfg_data;
                dgcpsd_pkg::CFG_SHORT_START: r_sg_start <= i_cfg_data[dgcpsd_pkg::GATE_START_W-1:0];
                dgcpsd_pkg::CFG_SHORT_END:   r_sg_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign run      = r_pos < POS_W'(MAX_PULSE_SAMPLES);
    assign pos_c    = CMP_W'(r_pos);
    assign in_long  = run && (pos_c >= CMP_W'(r_lg_start)) && (pos_c < CMP_W'(r_lg_end));
    assign in_short = run && (pos_c >= CMP_W'(r_sg_start)) && (pos_c < CMP_W'(r_sg_end));
    assign diff     = $signed({1'b0, i_pulse_baseline}) - $signed({1'b0, i_adc_sample});

    always_comb begin
        n_long  = r_long;
        n_short = r_short;
        if (in_long) begin
            n_long = dgcpsd_pkg::sat_acc((ACC_W+1)'(r_long) + (ACC_W+1)'(diff));
        end
        if (in_short) begin
            n_short = dgcpsd_pkg::sat_acc((ACC_W+1)'(r_short) + (ACC_W+1)'(diff));
        end
    end

    // gate sums and sample position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_long  <= '0;
            r_short <= '0;
        end else if (i_cmd.acc_en) begin
            if (i_last_sample) begin
                r_pos   <= '0;
                r_long  <= '0;
                r_short <= '0;
            end else begin
                r_long  <= n_long;
                r_short <= n_short;
                if (run) begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    assign lc_sc = (ACC_W+1)'(r_lc) - (ACC_W+1)'(r_sc);
    assign ge    = r_rem >= r_div;

    // snapshot, magnitudes and restoring divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en && i_last_sample) begin
            r_lc <= n_long;
            r_sc <= n_short;
        end
        if (i_cmd.abs_en) begin
            r_adiff <= lc_sc[ACC_W] ? unsigned'(-lc_sc) : unsigned'(lc_sc);
            r_ad    <= r_lc[ACC_W-1] ? unsigned'(-r_lc) : unsigned'(r_lc);
            r_neg   <= lc_sc[ACC_W] ^ r_lc[ACC_W-1];
            r_zero  <= r_lc == '0;
        end
        if (i_cmd.init_en) begin
            r_rem <= (REM_W'(r_adiff) << dgcpsd_pkg::NUM_SHIFT) + REM_W'(r_ad);
            r_div <= REM_W'(r_ad) << dgcpsd_pkg::DEN_SHIFT;
            r_cnt <= '0;
        end else if (i_cmd.div_en) begin
            if (ge) begin
                r_rem <= r_rem - r_div;
            end
            r_div <= r_div >> 1;
            r_quo <= {r_quo[dgcpsd_pkg::PSD_W-2:0], ge};
            r_cnt <= r_cnt + dgcpsd_pkg::CNT_W'(1);
        end
    end

    assign o_status.div_last = r_cnt == dgcpsd_pkg::CNT_W'(dgcpsd_pkg::DIV_STEPS - 1);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // top quotient bit set means the ratio reached two in magnitude
    always_comb begin
        q_mag = $signed({1'b0, r_quo[dgcpsd_pkg::PSD_W-2:0]});
        if (r_zero) begin
            psd = '0;
        end else if (r_neg) begin
            psd = r_quo[dgcpsd_pkg::PSD_W-1] ? dgcpsd_pkg::PSD_MIN : -q_mag;
        end else begin
            psd = r_quo[dgcpsd_pkg::PSD_W-1] ? dgcpsd_pkg::PSD_MAX : q_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_long_charge  <= r_lc;
            o_short_charge <= r_sc;
            o_psd_ratio    <= psd;
            o_psd_valid    <= !r_zero;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_PULSE_SAMPLES))
        else $error("sample position past limit");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_long >= dgcpsd_pkg::ACC_MIN) && (r_short >= dgcpsd_pkg::ACC_MIN))
        else $error("gate sum below saturation floor");

    a_psd_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_psd_valid == (o_long_charge != '0)))
        else $error("psd flag disagrees with long charge");

    a_psd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_psd_valid) |-> (o_psd_ratio == '0))
        else $error("psd not zero on invalid word");

endmodule

`default_nettype wire

/* verif/dual_gate_charge_psd_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for dual_gate_charge_psd: streams adc pulses in bursts,
// predicts long and short charge and the q1.14 psd of each pulse, checks every result word
// depends on dgcpsd_pkg and the dual_gate_charge_psd top level
module dual_gate_charge_psd_tb;

    localparam int     SAMPLE_W        = 12;
    localparam int     MAX_SAMPLES     = 1024;
    localparam int     DEF_LONG_START  = 4;
    localparam int     DEF_LONG_END    = 54;
    localparam int     DEF_SHORT_START = 4;
    localparam int     DEF_SHORT_END   = 14;
    localparam longint CHARGE_LIMIT    = 4194303;
    localparam longint Q14_ONE         = 16384;
    localparam int     STUCK_LIMIT     = 5000;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     DRAIN_CYCLES    = 30;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] baseline;
        logic                last;
    } t_adc_word;

    typedef struct {
        logic signed [dgcpsd_pkg::ACC_W-1:0] long_q;
        logic signed [dgcpsd_pkg::ACC_W-1:0] short_q;
        logic signed [dgcpsd_pkg::PSD_W-1:0] psd_q;
        logic                                psd_ok;
    } t_pulse_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [dgcpsd_pkg::CFG_IDX_W-1:0]    i_cfg_index = dgcpsd_pkg::CFG_LONG_START;
    logic [dgcpsd_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [SAMPLE_W-1:0]                 i_adc_sample = '0;
    logic [SAMPLE_W-1:0]                 i_pulse_baseline = '0;
    logic                                i_last_sample = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [dgcpsd_pkg::ACC_W-1:0] o_long_charge;
    logic signed [dgcpsd_pkg::ACC_W-1:0] o_short_charge;
    logic signed [dgcpsd_pkg::PSD_W-1:0] o_psd_ratio;
    logic                                o_psd_valid;

    // predictor copy of the gates and the running pulse
    int     long_start  = DEF_LONG_START;
    int     long_end    = DEF_LONG_END;
    int     short_start = DEF_SHORT_START;
    int     short_end   = DEF_SHORT_END;
    int     position    = 0;
    longint long_sum    = 0;
    longint short_sum   = 0;

    t_adc_word     pending_words[$];
    t_pulse_result pulses_due[$];
    t_adc_word     word_now;
    t_pulse_result due_now;

    int burst_left    = 1;
    int gap_left      = 0;
    int stall_pct     = 0;
    int stall_window  = 0;
    int hold_left     = 0;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;
    int words_sent    = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int gate_writes   = 0;
    int stuck_cycles  = 0;

    dual_gate_charge_psd DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_adc_sample     (i_adc_sample),
        .i_pulse_baseline (i_pulse_baseline),
        .i_last_sample    (i_last_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_long_charge    (o_long_charge),
        .o_short_charge   (o_short_charge),
        .o_psd_ratio      (o_psd_ratio),
        .o_psd_valid      (o_psd_valid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip_charge(input longint v);
        if (v > CHARGE_LIMIT) return CHARGE_LIMIT;
        if (v < -CHARGE_LIMIT) return -CHARGE_LIMIT;
        return v;
    endfunction

    // (long - short) / long in q1.14, rounded half away from zero, saturated
    function automatic longint psd_q14(input longint lc, input longint sc);
        longint num;
        longint an;
        longint ad;
        longint q;
        bit     neg;
        num = (lc - sc) * Q14_ONE;
        neg = (num < 0) != (lc < 0);
        an  = (num < 0) ? -num : num;
        ad  = (lc < 0) ? -lc : lc;
        q   = (an * 2 + ad) / (ad * 2);
        if (neg) return (q > 32768) ? -64'sd32768 : -q;
        return (q > 32767) ? 64'sd32767 : q;
    endfunction

    function automatic void integrate_sample(input t_adc_word w);
        longint        diff;
        longint        ratio;
        t_pulse_result r;
        diff = longint'(w.baseline) - longint'(w.sample);
        if (position < MAX_SAMPLES) begin
            if (position >= long_start && position < long_end) begin
                long_sum = clip_charge(long_sum + diff);
            end
            if (position >= short_start && position < short_end) begin
                short_sum = clip_charge(short_sum + diff);
            end
            position++;
        end
        if (w.last) begin
            r.long_q  = long_sum[dgcpsd_pkg::ACC_W-1:0];
            r.short_q = short_sum[dgcpsd_pkg::ACC_W-1:0];
            if (long_sum != 0) begin
                ratio    = psd_q14(long_sum, short_sum);
                r.psd_q  = ratio[dgcpsd_pkg::PSD_W-1:0];
                r.psd_ok = 1'b1;
            end else begin
                r.psd_q  = '0;
                r.psd_ok = 1'b0;
            end
            pulses_due.push_back(r);
            position  = 0;
            long_sum  = 0;
            short_sum = 0;
        end
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                integrate_sample(word_now);
                words_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    word_now = pending_words.pop_front();
                    i_adc_sample     <= word_now.sample;
                    i_pulse_baseline <= word_now.baseline;
                    i_last_sample    <= word_now.last;
                    i_in_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9)) inside
                            [0:2]:   gap_left = 0;
                            9:       gap_left = $urandom_range(10, 25);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result words, drives the receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pulses_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result word with none expected", $time);
                        $display("%0t: got long %0d short %0d psd %0d ok %0b",
                                 $time, o_long_charge, o_short_charge, o_psd_ratio,
                                 o_psd_valid);
                    end
                end else begin
                    due_now = pulses_due.pop_front();
                    results_seen++;
                    if (o_long_charge !== due_now.long_q || o_short_charge !== due_now.short_q ||
                        o_psd_ratio !== due_now.psd_q || o_psd_valid !== due_now.psd_ok) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: pulse %0d expected long %0d short %0d psd %0d ok %0b",
                                     $time, results_seen, due_now.long_q, due_now.short_q,
                                     due_now.psd_q, due_now.psd_ok);
                            $display("%0t: pulse %0d got      long %0d short %0d psd %0d ok %0b",
                                     $time, results_seen, o_long_charge, o_short_charge,
                                     o_psd_ratio, o_psd_valid);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_OFF_CYCLES;
                i_out_stall   <= 1'b1;
            end else begin
                if (stall_window == 0) begin
                    stall_window = 64;
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stall_window--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog on cycles where no word moves on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("dual_gate_charge_psd_tb failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_gate(input logic [dgcpsd_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic [dgcpsd_pkg::CFG_DATA_W-1:0] data;
        data = dgcpsd_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dgcpsd_pkg::CFG_LONG_START:
                long_start  = int'(data[dgcpsd_pkg::GATE_START_W-1:0]);
            dgcpsd_pkg::CFG_LONG_END:
                long_end    = int'(data[dgcpsd_pkg::GATE_END_W-1:0]);
            dgcpsd_pkg::CFG_SHORT_START:
                short_start = int'(data[dgcpsd_pkg::GATE_START_W-1:0]);
            dgcpsd_pkg::CFG_SHORT_END:
                short_end   = int'(data[dgcpsd_pkg::GATE_END_W-1:0]);
            default: ;
        endcase
        gate_writes++;
    endtask

    task automatic set_gates(input int ls, input int le, input int ss, input int se);
        write_gate(dgcpsd_pkg::CFG_LONG_START, ls);
        write_gate(dgcpsd_pkg::CFG_LONG_END, le);
        write_gate(dgcpsd_pkg::CFG_SHORT_START, ss);
        write_gate(dgcpsd_pkg::CFG_SHORT_END, se);
    endtask

    task automatic add_word(input int smp, input int base, input bit last);
        t_adc_word w;
        w.sample   = SAMPLE_W'(smp);
        w.baseline = SAMPLE_W'(base);
        w.last     = last;
        pending_words.push_back(w);
    endtask

    // mostly pulses below a fixed baseline, some fully random, some with a wandering baseline
    task automatic add_pulse(input int len);
        int kind;
        int amp;
        int smp;
        int base;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 4095);
        amp  = $urandom_range(0, 4095);
        for (int i = 0; i < len; i++) begin
            if (kind < 6) begin
                smp = base - int'($urandom_range(0, amp));
                if (smp < 0 || $urandom_range(0, 7) == 0) smp = $urandom_range(0, 4095);
            end else begin
                smp = $urandom_range(0, 4095);
            end
            if (kind == 9) base = $urandom_range(0, 4095);
            add_word(smp, base, i == len - 1);
        end
    endtask

    task automatic run_random_phase(input int target);
        int added;
        int len;
        added = 0;
        while (added < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 70) : $urandom_range(1, 20);
            add_pulse(len);
            added += len;
        end
    endtask

    task automatic drain;
        while (pending_words.size() != 0 || i_in_valid || pulses_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int rand_start();
        int s;
        s = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 24);
        return s | ($urandom_range(0, 1) << 10);
    endfunction

    function automatic int rand_end();
        return ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(0, 45);
    endfunction

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // gates at their reset values
        add_pulse(60);
        run_random_phase(40);
        drain();

        // directed pulses on narrow gates
        set_gates(0, 8, 0, 3);
        repeat (3) add_word(0, 4095, 1'b0);
        add_word(0, 4095, 1'b1);
        repeat (2) add_word(4095, 0, 1'b0);
        add_word(4095, 0, 1'b1);
        add_word(2730, 2730, 1'b0);
        add_word(2730, 2730, 1'b1);
        add_word(1365, 2730, 1'b1);
        // long charge of one against a large short charge, both signs
        repeat (3) add_word(900, 1000, 1'b0);
        add_word(1299, 1000, 1'b0);
        add_word(1000, 1000, 1'b1);
        repeat (3) add_word(1100, 1000, 1'b0);
        add_word(699, 1000, 1'b0);
        add_word(1000, 1000, 1'b1);
        drain();
        // short gate with start equal to end, then start above end
        write_gate(dgcpsd_pkg::CFG_SHORT_START, 5);
        write_gate(dgcpsd_pkg::CFG_SHORT_END, 5);
        add_pulse(3);
        drain();
        write_gate(dgcpsd_pkg::CFG_SHORT_START, 7);
        write_gate(dgcpsd_pkg::CFG_SHORT_END, 2);
        add_pulse(2);
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       set_gates(0, 1024, rand_start(), rand_end());
                1:       set_gates(1023 | 1024, 1024, 1023, 0);
                default: set_gates(rand_start(), rand_end(), rand_start(), rand_end());
            endcase
            if (p == 2) pressure_armed = 1'b1;
            run_random_phase(80);
            drain();
        end

        // pulses past the sample limit with full-scale charge of both signs
        set_gates(0, 1024, 1020, 1024);
        repeat (1029) add_word(0, 4095, 1'b0);
        add_word(0, 4095, 1'b1);
        repeat (1029) add_word(4095, 0, 1'b0);
        add_word(4095, 0, 1'b1);
        add_pulse(5);
        drain();

        $display("run covered %0d adc words and %0d pulse results over %0d gate writes,",
                 words_sent, results_seen, gate_writes);
        $display("with reset gates, empty and full gates, overlong pulses and a %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && pulses_due.size() == 0) begin
            $display("dual_gate_charge_psd_tb passed");
        end else begin
            $display("dual_gate_charge_psd_tb failed");
        end
        $finish;
    end

endmodule
